FILE: design/dma_transmit_ring_buffer_unit_macros.svh
// assertion helpers for the ring buffer unit
`ifndef DMA_TRANSMIT_RING_BUFFER_UNIT_MACROS_SVH
`define DMA_TRANSMIT_RING_BUFFER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DTRB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtrb assertion failed");

// next-cycle implication, checked outside reset
`define DTRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtrb assertion failed");

`endif

FILE: design/dtrb_pkg.sv
package dtrb_pkg;

  typedef enum logic [1:0] {
    KIND_PUT  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  localparam logic [7:0] MARKER_BYTE = 8'h5E;

endpackage

FILE: design/dtrb_ram.sv
module dtrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/dma_transmit_ring_buffer_unit.sv
// Transmit byte ring buffer for a DMA-fed serial sender, one slot kept free. Each accepted
// word gives exactly one result word. Puts, transfer-done and unused-kind words finish in
// the idle state; a read visits a read state too, as the byte store read is registered; a
// put that inserts the overrun marker and then stores its own byte visits a data state
// too, as the byte store has a single write port. The result register lets the next word
// in while a result waits, as long as it is taken in the same cycle.
`include "dma_transmit_ring_buffer_unit_macros.svh"

module dma_transmit_ring_buffer_unit
  import dtrb_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data_byte,
  input  logic [4:0] in_read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_accepted,
  output logic       out_marker_stored,
  output logic       out_burst_valid,
  output logic [4:0] out_burst_start,
  output logic [4:0] out_burst_count,
  output logic       out_sender_busy,
  output logic       out_overrun_flag,
  output logic [7:0] out_read_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DATA = 3'b010,
    ST_READ = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] be_r, be_nxt;
  logic          running_r, running_nxt;
  logic          ovp_r, ovp_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic [7:0]    pend_byte_r, pend_byte_nxt;
  logic          rd_ok_r, rd_ok_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          acc_r, acc_nxt;
  logic          mark_r, mark_nxt;
  logic          bv_r, bv_nxt;
  logic [4:0]    bs_r, bs_nxt;
  logic [4:0]    bc_r, bc_nxt;
  logic          busy_r, busy_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    rdata_r, rdata_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          accept;
  logic [AW-1:0] wp1, wp2;
  logic          full0, full1;
  logic          launch_req;
  logic [AW-1:0] lr, lw;
  logic          put_we;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  dtrb_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign wp1       = next_slot(wp_r);
  assign wp2       = next_slot(wp1);
  assign full0     = (wp1 == rp_r);
  assign full1     = (wp2 == rp_r);
  assign ram_raddr = AW'(in_read_index);

  always_comb begin
    state_nxt     = state_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    be_nxt        = be_r;
    running_nxt   = running_r;
    ovp_nxt       = ovp_r;
    pend_addr_nxt = pend_addr_r;
    pend_byte_nxt = pend_byte_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    acc_nxt       = acc_r;
    mark_nxt      = mark_r;
    bv_nxt        = bv_r;
    bs_nxt        = bs_r;
    bc_nxt        = bc_r;
    busy_nxt      = busy_r;
    ovf_nxt       = ovf_r;
    rdata_nxt     = rdata_r;
    put_we        = 1'b0;
    ram_waddr     = wp_r;
    ram_wdata     = in_data_byte;
    launch_req    = 1'b0;
    lr            = rp_r;
    lw            = wp_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          acc_nxt   = 1'b0;
          mark_nxt  = 1'b0;
          rdata_nxt = '0;
          unique case (in_kind)
            KIND_PUT: begin
              launch_req = !running_r;
              if (ovp_r) begin
                if (!full0) begin
                  put_we    = 1'b1;
                  ram_wdata = MARKER_BYTE;
                  mark_nxt  = 1'b1;
                  lw        = wp1;
                  ovp_nxt   = full1;
                  if (full1) begin
                    wp_nxt = wp1;
                  end else begin
                    acc_nxt       = 1'b1;
                    wp_nxt        = wp2;
                    state_nxt     = ST_DATA;
                    pend_addr_nxt = wp1;
                    pend_byte_nxt = in_data_byte;
                  end
                end
              end else if (full0) begin
                ovp_nxt = 1'b1;
              end else begin
                put_we  = 1'b1;
                acc_nxt = 1'b1;
                wp_nxt  = wp1;
                lw      = wp1;
              end
            end
            KIND_DONE: begin
              if (running_r) begin
                rp_nxt = be_r;
                lr     = be_r;
                if (wp_r == be_r) begin
                  running_nxt = 1'b0;
                end else begin
                  launch_req = 1'b1;
                end
              end
            end
            KIND_READ: begin
              state_nxt = ST_READ;
              rd_ok_nxt = (32'(in_read_index) < BUFFER_DEPTH);
            end
            default: begin
            end
          endcase

          bv_nxt = launch_req;
          bs_nxt = '0;
          bc_nxt = '0;
          if (launch_req) begin
            running_nxt = 1'b1;
            bs_nxt      = 5'(lr);
            if (lr < lw) begin
              bc_nxt = 5'(CW'(lw) - CW'(lr));
              be_nxt = lw;
            end else begin
              bc_nxt = 5'(CW'(BUFFER_DEPTH) - CW'(lr));
              be_nxt = '0;
            end
          end
          busy_nxt      = running_nxt;
          ovf_nxt       = ovp_nxt;
          out_valid_nxt = (in_kind != KIND_READ);
        end
      end
      ST_DATA: begin
        put_we    = 1'b1;
        ram_waddr = pend_addr_r;
        ram_wdata = pend_byte_r;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        rdata_nxt     = rd_ok_r ? ram_rdata : 8'h00;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign ram_we = put_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      be_r        <= '0;
      running_r   <= 1'b0;
      ovp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      be_r        <= be_nxt;
      running_r   <= running_nxt;
      ovp_r       <= ovp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_byte_r <= pend_byte_nxt;
    rd_ok_r     <= rd_ok_nxt;
    acc_r       <= acc_nxt;
    mark_r      <= mark_nxt;
    bv_r        <= bv_nxt;
    bs_r        <= bs_nxt;
    bc_r        <= bc_nxt;
    busy_r      <= busy_nxt;
    ovf_r       <= ovf_nxt;
    rdata_r     <= rdata_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = acc_r;
  assign out_marker_stored = mark_r;
  assign out_burst_valid   = bv_r;
  assign out_burst_start   = bs_r;
  assign out_burst_count   = bc_r;
  assign out_sender_busy   = busy_r;
  assign out_overrun_flag  = ovf_r;
  assign out_read_data     = rdata_r;

  // sender idle means nothing is queued
  `DTRB_ASSERT_IMPL(a_idle_empty, !running_r, wp_r == rp_r)
  // a launched burst leaves the sender busy
  `DTRB_ASSERT_IMPL(a_burst_busy, out_valid && out_burst_valid, out_sender_busy)
  // a stored put byte clears the overrun condition
  `DTRB_ASSERT_IMPL(a_acc_clears_ovf, out_valid && out_accepted, !out_overrun_flag)
  // a read word always passes through the read state while waiting on the byte store
  `DTRB_ASSERT_NEXT(a_read_wait, accept && (in_kind == KIND_READ), state_r == ST_READ)

endmodule
